// File: rtl/fragment_reassembly_tracker_assert.svh
// ----------------------------------------------------------------------------
// Fragment reassembly tracker assertion macros
// Clocked assertion helpers used by the tracker back end.
// ----------------------------------------------------------------------------
`ifndef FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// check a property at every clock edge outside reset
`define FRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition leads to a consequence in the next cycle
`define FRT_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared types, codes and sizes of the tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int TableDepth   = 16;
  localparam int MaxFragments = 32;
  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_EXPIRE = 2'd2,
    CMD_POLL   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SMALL_FRAG  = 4'd1,
    ST_FRAG_BIG    = 4'd2,
    ST_FULL        = 4'd3,
    ST_DUP_START   = 4'd4,
    ST_NOT_FOUND   = 4'd5,
    ST_OFFSET_OVF  = 4'd6,
    ST_DUP_FRAG    = 4'd7,
    ST_NONE_DONE   = 4'd8,
    ST_TOO_MANY    = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CHECK,
    S_DIV,
    S_APPLY,
    S_SWEEP,
    S_RESP
  } state_e;

  typedef enum logic [0:0] {
    REG_EXPIRY  = 1'b0,
    REG_MIN_FRAG = 1'b1
  } reg_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] datagram_tag;
    logic [15:0] source_addr;
    logic [15:0] dest_addr;
    logic [7:0]  traffic_class;
    logic [15:0] message_size;
    logic [15:0] fragment_size;
    logic [15:0] fragment_offset;
    logic [31:0] now_seconds;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] done_tag;
    logic [15:0] done_source;
    logic [15:0] done_dest;
    logic [7:0]  done_class;
    logic [15:0] done_size;
    logic [4:0]  dropped_count;
    logic [4:0]  entries_in_use;
  } result_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] key;
    logic [15:0] dest;
    logic [7:0]  cls;
    logic [15:0] msz;
    logic [15:0] fsz;
    logic [15:0] off;
    logic [31:0] now;
    logic [32:0] limit;
    status_e     pre_status;
  } op_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] dest;
    logic [7:0]  cls;
    logic [15:0] msz;
    logic [15:0] fsz;
    logic [31:0] map;
    logic [31:0] stamp;
  } entry_t;

endpackage

// File: rtl/frt_front.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker front end
// Accepts commands, runs the size checks of start, queues the operations.
// ----------------------------------------------------------------------------
module frt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  frt_pkg::item_t  item_i,
  input  logic [15:0]     expiry_i,
  input  logic [15:0]     min_frag_i,
  input  logic            pop_i,
  output logic            op_valid_o,
  output frt_pkg::op_t    op_o
);
  import frt_pkg::*;

  op_t        fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  op_t        op_new;

  assign busy       = (fill_q == 2'd2);
  assign push       = start && !busy;
  assign op_valid_o = (fill_q != 2'd0);
  assign op_o       = fifo_q[rd_ptr_q];

  always_comb begin
    op_new.cmd   = item_i.cmd;
    op_new.key   = {item_i.datagram_tag, item_i.source_addr};
    op_new.dest  = item_i.dest_addr;
    op_new.cls   = item_i.traffic_class;
    op_new.msz   = item_i.message_size;
    op_new.fsz   = item_i.fragment_size;
    op_new.off   = item_i.fragment_offset;
    op_new.now   = item_i.now_seconds;
    op_new.limit = {1'b0, item_i.now_seconds} - {17'd0, expiry_i};
    op_new.pre_status = ST_OK;
    if (item_i.cmd == CMD_START) begin
      if (item_i.fragment_size == 16'd0 || item_i.fragment_size < min_frag_i) begin
        op_new.pre_status = ST_SMALL_FRAG;
      end else if (item_i.fragment_size > item_i.message_size) begin
        op_new.pre_status = ST_FRAG_BIG;
      end
    end
  end

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

// File: rtl/frt_div.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker divider
// Restoring 16-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic [15:0] quot_o,
  output logic        done_o
);
  logic [16:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d, dvs_q, dvs_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [16:0] rem_sh;

  assign quot_o = quo_q;
  assign done_o = done_q;
  assign rem_sh = {rem_q[15:0], quo_q[15]};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = 17'd0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = 5'd0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

// File: rtl/frt_back.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker back end
// Holds the sorted table and carries out start, add, expire and poll.
// ----------------------------------------------------------------------------
`include "fragment_reassembly_tracker_assert.svh"

module frt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  input  frt_pkg::op_t     op_i,
  output logic             pop_o,
  output logic             div_start_o,
  output logic [15:0]      div_dividend_o,
  output logic [15:0]      div_divisor_o,
  input  logic [15:0]      div_quot_i,
  input  logic             div_done_i,
  output logic             result_valid_o,
  output frt_pkg::result_t result_o
);
  import frt_pkg::*;

  state_e          state_q, state_d;
  op_t             op_q, op_d;
  entry_t          entry_q [TableDepth];
  entry_t          entry_d [TableDepth];
  logic [CntW-1:0] count_q, count_d, pos_q, pos_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] idx_q, idx_d, rd_idx;
  result_t         res_q, res_d;
  entry_t          rd;

  logic [TableDepth-1:0] lt, eq, full_map;
  logic [CntW-1:0]       lb;
  logic [CntW-1:0]       found_idx;
  logic                  match, found, expired, chk_fail;
  logic                  ins_en, rm_en;
  logic [CntW-1:0]       rm_idx;
  logic [16:0]           end_off;
  logic [31:0]           bit_mask;
  entry_t                new_ent;

  assign rd_idx  = (state_q == S_SWEEP) ? idx_q : pos_q[IdxW-1:0];
  assign rd      = entry_q[rd_idx];
  assign expired = $signed(op_q.limit) > $signed({1'b0, rd.stamp});
  assign end_off = {1'b0, op_q.off} + {1'b0, op_q.fsz};
  assign chk_fail = (end_off > {1'b0, rd.msz}) || (rd.fsz == 16'd0);
  assign bit_mask = (div_quot_i < 16'(MaxFragments)) ? (32'd1 << div_quot_i[4:0]) : 32'd0;

  always_comb begin
    found_idx = '0;
    for (int i = 0; i < TableDepth; i++) begin
      lt[i] = (CntW'(i) < count_q) && (entry_q[i].key < op_q.key);
      eq[i] = (CntW'(i) < count_q) && (entry_q[i].key == op_q.key);
      full_map[i] = (CntW'(i) < count_q) && (entry_q[i].map == 32'hFFFF_FFFF);
    end
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (full_map[i]) begin
        found_idx = CntW'(i);
      end
    end
    lb    = CntW'($countones(lt));
    match = |eq;
    found = |full_map;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          if (op_i.cmd == CMD_EXPIRE) begin
            state_d = (count_q == '0) ? S_RESP : S_SWEEP;
          end else if (op_i.cmd == CMD_START && op_i.pre_status != ST_OK) begin
            state_d = S_RESP;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        priority case (op_q.cmd)
          CMD_START: state_d = S_DIV;
          CMD_ADD:   state_d = match ? S_CHECK : S_RESP;
          default:   state_d = found ? S_APPLY : S_RESP;
        endcase
      end
      S_CHECK: state_d = chk_fail ? S_RESP : S_DIV;
      S_DIV:   state_d = div_done_i ? S_APPLY : S_DIV;
      S_APPLY: state_d = S_RESP;
      S_SWEEP: state_d = (idx_q == '0) ? S_RESP : S_SWEEP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d     = op_q;
    res_d    = res_q;
    pos_d    = pos_q;
    hit_d    = hit_q;
    idx_d    = idx_q;
    ins_en   = 1'b0;
    rm_en    = 1'b0;
    rm_idx   = pos_q;
    pop_o    = 1'b0;
    div_start_o    = 1'b0;
    div_dividend_o = (op_q.cmd == CMD_START) ? (op_q.msz - 16'd1) : op_q.off;
    div_divisor_o  = (op_q.cmd == CMD_START) ? op_q.fsz : rd.fsz;
    new_ent.key   = op_q.key;
    new_ent.dest  = op_q.dest;
    new_ent.cls   = op_q.cls;
    new_ent.msz   = op_q.msz;
    new_ent.fsz   = op_q.fsz;
    new_ent.map   = 32'hFFFF_FFFE << div_quot_i[4:0];
    new_ent.stamp = op_q.now;
    for (int i = 0; i < TableDepth; i++) begin
      entry_d[i] = entry_q[i];
    end
    count_d = count_q;

    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          pop_o  = 1'b1;
          op_d   = op_i;
          res_d  = '0;
          res_d.status = op_i.pre_status;
          idx_d  = IdxW'(count_q - CntW'(1));
        end
      end
      S_LOOK: begin
        pos_d = (op_q.cmd == CMD_POLL) ? found_idx : lb;
        hit_d = match;
        if (op_q.cmd == CMD_START) begin
          div_start_o = 1'b1;
        end else if (op_q.cmd == CMD_ADD && !match) begin
          res_d.status = ST_NOT_FOUND;
        end else if (op_q.cmd == CMD_POLL && !found) begin
          res_d.status = ST_NONE_DONE;
        end
      end
      S_CHECK: begin
        if (chk_fail) begin
          res_d.status = ST_OFFSET_OVF;
        end else begin
          div_start_o = 1'b1;
        end
      end
      S_APPLY: begin
        priority case (op_q.cmd)
          CMD_START: begin
            if (div_quot_i >= 16'(MaxFragments)) begin
              res_d.status = ST_TOO_MANY;
            end else if (count_q >= CntW'(TableDepth)) begin
              res_d.status = ST_FULL;
            end else if (hit_q) begin
              res_d.status = ST_DUP_START;
            end else begin
              ins_en = 1'b1;
            end
          end
          CMD_ADD: begin
            if ((rd.map & bit_mask) != 32'd0) begin
              res_d.status = ST_DUP_FRAG;
            end else begin
              entry_d[pos_q[IdxW-1:0]].map = rd.map | bit_mask;
            end
          end
          default: begin
            res_d.done_tag    = rd.key[31:16];
            res_d.done_source = rd.key[15:0];
            res_d.done_dest   = rd.dest;
            res_d.done_class  = rd.cls;
            res_d.done_size   = rd.msz;
            rm_en = 1'b1;
          end
        endcase
      end
      S_SWEEP: begin
        if (expired) begin
          rm_en  = 1'b1;
          rm_idx = CntW'(idx_q);
          res_d.dropped_count = res_q.dropped_count + 5'd1;
        end
        idx_d = idx_q - IdxW'(1);
      end
      default: begin
      end
    endcase

    if (ins_en) begin
      for (int i = 1; i < TableDepth; i++) begin
        if (CntW'(i) > pos_q && CntW'(i) <= count_q) begin
          entry_d[i] = entry_q[i-1];
        end
      end
      entry_d[pos_q[IdxW-1:0]] = new_ent;
      count_d = count_q + CntW'(1);
    end
    if (rm_en) begin
      for (int i = 0; i < TableDepth - 1; i++) begin
        if (CntW'(i) >= rm_idx) begin
          entry_d[i] = entry_q[i+1];
        end
      end
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    result_valid_o = (state_q == S_RESP);
    result_o = res_q;
    result_o.entries_in_use = 5'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    res_q <= res_d;
    pos_q <= pos_d;
    hit_q <= hit_d;
    idx_q <= idx_d;
    for (int i = 0; i < TableDepth; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  `FRT_ASSERT(a_count_bound, count_q <= CntW'(TableDepth), "table count beyond depth")
  `FRT_ASSERT_NEXT(a_ins_grows, ins_en, count_q == $past(count_q) + CntW'(1),
                   "insert did not grow the table")
  `FRT_ASSERT_NEXT(a_resp_single, result_valid_o, !result_valid_o, "result held past one cycle")
  `FRT_ASSERT(a_div_wait, (state_q == S_DIV) || !div_done_i || (state_q == S_LOOK) ||
              (state_q == S_CHECK), "divider finished outside a divide")

endmodule

// File: rtl/fragment_reassembly_tracker.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Sorted table of datagrams under reassembly with start, add, expire, poll.
//
//   channel   handshake                         payload
//   command   start / busy                      item_i   (frt_pkg::item_t)
//   result    result_valid_o, one-cycle strobe  result_o (frt_pkg::result_t)
//   config    APB write/read, pready tied high  pwdata / prdata
//
// Early rejects go straight to the result. Start passes lookup, divide, apply;
// add passes lookup, check, divide, apply, ending after lookup on an unknown key
// or after check on an offset overflow; poll passes lookup and apply, or only
// lookup when nothing is complete; expire sweeps one entry per sweep cycle.
// A two-entry queue lets up to two commands wait.
// Reset clears the table count and loads expiry 120 and minimum fragment 40.
// busy rises only when the queue is full; results cannot be stalled.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  frt_pkg::item_t   item_i,
  output logic             result_valid_o,
  output frt_pkg::result_t result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import frt_pkg::*;

  logic [15:0] expiry_q, expiry_d, min_frag_q, min_frag_d;
  logic        pop, op_valid, div_start, div_done, wr_en;
  op_t         op;
  logic [15:0] div_dividend, div_divisor, div_quot;
  reg_e        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    expiry_d   = expiry_q;
    min_frag_d = min_frag_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_EXPIRY:   expiry_d   = pwdata[15:0];
        REG_MIN_FRAG: min_frag_d = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_EXPIRY:   prdata = {16'd0, expiry_q};
      REG_MIN_FRAG: prdata = {16'd0, min_frag_q};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q   <= 16'd120;
      min_frag_q <= 16'd40;
    end else begin
      expiry_q   <= expiry_d;
      min_frag_q <= min_frag_d;
    end
  end

  frt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .expiry_i   (expiry_q),
    .min_frag_i (min_frag_q),
    .pop_i      (pop),
    .op_valid_o (op_valid),
    .op_o       (op)
  );

  frt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  frt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_i           (op),
    .pop_o          (pop),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_quot_i     (div_quot),
    .div_done_i     (div_done),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// File: tb/sv/fragment_reassembly_tracker_test.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker testbench
// Drives start, add, expire and poll commands through the command port,
// predicts every result with a behavioral copy of the sorted table, and
// compares each result strobe field by field. Registers are written over
// APB between phases while the tracker is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fragment_reassembly_tracker_test;
  import frt_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 100;

  typedef struct {
    logic [31:0] key;
    logic [15:0] dest;
    logic [7:0]  cls;
    logic [15:0] msz;
    logic [15:0] fsz;
    logic [31:0] map;
    logic [31:0] stamp;
  } slot_t;

  typedef struct {
    item_t   item;
    logic    has_exp;
    status_e exp_status;
    int      exp_count;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  item_t       item_i;
  logic        result_valid_o;
  result_t     result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fragment_reassembly_tracker DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  slot_t   table_q[$];
  int      expiry_s;
  int      min_frag;
  result_t pending_results[$];
  int      error_count;
  int      idle_cycles;
  logic    no_idling;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic int find_pos(input logic [31:0] key);
    int i;
    i = 0;
    while (i < table_q.size() && table_q[i].key < key) i++;
    return i;
  endfunction

  function automatic result_t predict_tracker(input item_t it);
    result_t     r;
    logic [31:0] key;
    int          pos;
    int unsigned last;
    int unsigned slot_n;
    logic [31:0] bit_m;
    longint      lim;
    slot_t       s;
    r   = '0;
    key = {it.datagram_tag, it.source_addr};
    case (it.cmd)
      CMD_START: begin
        if (it.fragment_size == 0 || it.fragment_size < min_frag) begin
          r.status = ST_SMALL_FRAG;
        end else if (it.fragment_size > it.message_size) begin
          r.status = ST_FRAG_BIG;
        end else begin
          last = (int'(it.message_size) - 1) / int'(it.fragment_size);
          pos  = find_pos(key);
          if (last >= MaxFragments) r.status = ST_TOO_MANY;
          else if (table_q.size() >= TableDepth) r.status = ST_FULL;
          else if (pos < table_q.size() && table_q[pos].key == key) begin
            r.status = ST_DUP_START;
          end else begin
            s.key = key;  s.dest = it.dest_addr;  s.cls = it.traffic_class;
            s.msz = it.message_size;  s.fsz = it.fragment_size;
            s.map = 32'hFFFF_FFFE << last;  s.stamp = it.now_seconds;
            table_q.insert(pos, s);
            r.status = ST_OK;
          end
        end
      end
      CMD_ADD: begin
        pos = find_pos(key);
        if (pos >= table_q.size() || table_q[pos].key != key) r.status = ST_NOT_FOUND;
        else if (int'(it.fragment_offset) + int'(it.fragment_size) > int'(table_q[pos].msz))
          r.status = ST_OFFSET_OVF;
        else begin
          slot_n = it.fragment_offset / table_q[pos].fsz;
          bit_m  = (slot_n < 32) ? (32'd1 << slot_n) : 32'd0;
          if ((table_q[pos].map & bit_m) != 0) r.status = ST_DUP_FRAG;
          else begin
            table_q[pos].map |= bit_m;
            r.status = ST_OK;
          end
        end
      end
      CMD_EXPIRE: begin
        lim = longint'(it.now_seconds) - longint'(expiry_s);
        for (int i = table_q.size() - 1; i >= 0; i--) begin
          if (lim > longint'(table_q[i].stamp)) begin
            table_q.delete(i);
            r.dropped_count++;
          end
        end
        r.status = ST_OK;
      end
      default: begin
        r.status = ST_NONE_DONE;
        for (int i = 0; i < table_q.size(); i++) begin
          if (table_q[i].map == 32'hFFFF_FFFF) begin
            r.done_tag    = table_q[i].key[31:16];
            r.done_source = table_q[i].key[15:0];
            r.done_dest   = table_q[i].dest;
            r.done_class  = table_q[i].cls;
            r.done_size   = table_q[i].msz;
            table_q.delete(i);
            r.status = ST_OK;
            break;
          end
        end
      end
    endcase
    r.entries_in_use = 5'(table_q.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(result_o.status), 32'hx);
      end else begin
        want = pending_results.pop_front();
        if (result_o.status != want.status)
          report_mismatch("status", 32'(result_o.status), 32'(want.status));
        if (result_o.done_tag != want.done_tag)
          report_mismatch("done_tag", 32'(result_o.done_tag), 32'(want.done_tag));
        if (result_o.done_source != want.done_source)
          report_mismatch("done_source", 32'(result_o.done_source), 32'(want.done_source));
        if (result_o.done_dest != want.done_dest)
          report_mismatch("done_dest", 32'(result_o.done_dest), 32'(want.done_dest));
        if (result_o.done_class != want.done_class)
          report_mismatch("done_class", 32'(result_o.done_class), 32'(want.done_class));
        if (result_o.done_size != want.done_size)
          report_mismatch("done_size", 32'(result_o.done_size), 32'(want.done_size));
        if (result_o.dropped_count != want.dropped_count)
          report_mismatch("dropped_count", 32'(result_o.dropped_count),
                          32'(want.dropped_count));
        if (result_o.entries_in_use != want.entries_in_use)
          report_mismatch("entries_in_use", 32'(result_o.entries_in_use),
                          32'(want.entries_in_use));
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || result_valid_o || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input reg_e idx, input logic [15:0] value);
    @(posedge clk_i);
    psel <= 1'b1;  penable <= 1'b0;  pwrite <= 1'b1;
    paddr <= 3'(idx) << 2;  pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;  penable <= 1'b0;  pwrite <= 1'b0;
    if (idx == REG_EXPIRY) expiry_s = value;
    else min_frag = value;
  endtask

  task automatic check_reg(input reg_e idx, input logic [15:0] want);
    @(posedge clk_i);
    psel <= 1'b1;  penable <= 1'b0;  pwrite <= 1'b0;  paddr <= 3'(idx) << 2;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] != want) report_mismatch("register read", prdata, 32'(want));
    psel <= 1'b0;  penable <= 1'b0;
  endtask

  task automatic send_item(input item_t it, input logic has_exp, input status_e st,
                           input int cnt);
    result_t want;
    int gap;
    if (!no_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    want = predict_tracker(it);
    if (has_exp) begin
      if (want.status != st) report_mismatch("directed status", 32'(want.status), 32'(st));
      if (cnt >= 0 && want.entries_in_use != cnt)
        report_mismatch("directed count", 32'(want.entries_in_use), 32'(cnt));
    end
    pending_results.push_back(want);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic item_t make_item(input cmd_e c, input logic [15:0] tag,
                                      input logic [15:0] src, input logic [15:0] msz,
                                      input logic [15:0] fsz, input logic [15:0] off,
                                      input logic [31:0] now);
    item_t it;
    it.cmd = c;  it.datagram_tag = tag;  it.source_addr = src;
    it.dest_addr = 16'($urandom);  it.traffic_class = 8'($urandom);
    it.message_size = msz;  it.fragment_size = fsz;  it.fragment_offset = off;
    it.now_seconds = now;
    return it;
  endfunction

  // mostly well-formed: start a message, add all its fragments in random order
  task automatic send_message(input logic [31:0] now);
    item_t       it;
    logic [15:0] tag, src, fsz, msz;
    int          nfrag;
    int          order[$];
    tag   = 16'($urandom_range(0, 7));
    src   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    fsz   = 16'($urandom_range(min_frag == 0 ? 1 : min_frag, min_frag + 60));
    nfrag = $urandom_range(1, 32);
    msz   = 16'(int'(fsz) * (nfrag - 1) + $urandom_range(1, fsz));
    it    = make_item(CMD_START, tag, src, msz, fsz, 16'($urandom), now);
    send_item(it, 1'b0, ST_OK, -1);
    for (int i = 0; i < nfrag; i++) order.push_back(i);
    order.shuffle();
    foreach (order[i]) begin
      it = make_item(CMD_ADD, tag, src, 16'($urandom), 16'($urandom_range(1, fsz)),
                     16'(order[i] * fsz), now);
      if (int'(it.fragment_offset) + int'(it.fragment_size) > int'(msz))
        it.fragment_size = msz - it.fragment_offset;
      if ($urandom_range(0, 15) == 0) it.fragment_size = 16'($urandom);
      send_item(it, 1'b0, ST_OK, -1);
      if ($urandom_range(0, 10) == 0) begin
        it.cmd = CMD_POLL;
        send_item(it, 1'b0, ST_OK, -1);
      end
    end
  endtask

  task automatic send_noise(input logic [31:0] now);
    item_t        it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(item_t)-1:0];
    if ($urandom_range(0, 1)) it.datagram_tag = 16'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) it.now_seconds = now + $urandom_range(0, 300) - 150;
    if ($urandom_range(0, 1)) it.message_size = 16'($urandom_range(0, 2000));
    if ($urandom_range(0, 1)) it.fragment_size = 16'($urandom_range(0, 200));
    send_item(it, 1'b0, ST_OK, -1);
  endtask

  row_t rows[$];
  item_t it;
  logic [31:0] clock_s;

  initial begin
    rst_ni = 1'b0;  start = 1'b0;  item_i = '0;
    psel = 1'b0;  penable = 1'b0;  pwrite = 1'b0;  paddr = '0;  pwdata = '0;
    error_count = 0;  expiry_s = 120;  min_frag = 40;  no_idling = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reg(REG_EXPIRY, 16'd120);
    check_reg(REG_MIN_FRAG, 16'd40);

    rows = '{
      '{make_item(CMD_POLL, 0, 0, 0, 0, 0, 0), 1, ST_NONE_DONE, 0},
      '{make_item(CMD_ADD, 1, 1, 100, 40, 0, 0), 1, ST_NOT_FOUND, 0},
      '{make_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, ST_OK, 0},
      '{make_item(CMD_START, 1, 1, 100, 0, 0, 0), 1, ST_SMALL_FRAG, 0},
      '{make_item(CMD_START, 1, 1, 100, 39, 0, 0), 1, ST_SMALL_FRAG, 0},
      '{make_item(CMD_START, 1, 1, 100, 101, 0, 0), 1, ST_FRAG_BIG, 0},
      '{make_item(CMD_START, 1, 1, 1281, 40, 0, 0), 1, ST_TOO_MANY, 0},
      '{make_item(CMD_START, 1, 1, 1280, 40, 0, 10), 1, ST_OK, 1},
      '{make_item(CMD_START, 1, 1, 100, 50, 0, 10), 1, ST_DUP_START, 1},
      '{make_item(CMD_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 32'hFFFF_FFFF),
        1, ST_OK, 2},
      '{make_item(CMD_START, 0, 0, 40, 40, 0, 0), 1, ST_OK, 3},
      '{make_item(CMD_ADD, 1, 1, 0, 41, 1240, 0), 1, ST_OFFSET_OVF, 3},
      '{make_item(CMD_ADD, 1, 1, 0, 0, 1280, 0), 1, ST_OK, 3},
      '{make_item(CMD_ADD, 1, 1, 0, 40, 1240, 0), 1, ST_OK, 3},
      '{make_item(CMD_ADD, 1, 1, 0, 40, 1240, 0), 1, ST_DUP_FRAG, 3},
      '{make_item(CMD_ADD, 0, 0, 0, 40, 0, 0), 1, ST_OK, 3},
      '{make_item(CMD_ADD, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0, 0), 1, ST_OK, 3},
      '{make_item(CMD_POLL, 0, 0, 0, 0, 0, 0), 1, ST_OK, 2},
      '{make_item(CMD_POLL, 0, 0, 0, 0, 0, 0), 1, ST_OK, 1},
      '{make_item(CMD_POLL, 0, 0, 0, 0, 0, 0), 1, ST_NONE_DONE, 1},
      '{make_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 130), 1, ST_OK, 1},
      '{make_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 131), 1, ST_OK, 0}
    };
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_exp, rows[i].exp_status,
                                rows[i].exp_count);
    // fill the table to overflow
    for (int i = 0; i < TableDepth + 1; i++) begin
      it = make_item(CMD_START, 16'(i), 0, 80, 40, 0, 0);
      send_item(it, 1'b1, (i < TableDepth) ? ST_OK : ST_FULL, (i < TableDepth) ? i + 1 : i);
    end
    drain();
    write_reg(REG_MIN_FRAG, 16'd0);
    it = make_item(CMD_START, 9, 9, 5, 0, 0, 0);
    send_item(it, 1'b1, ST_SMALL_FRAG, TableDepth);
    it = make_item(CMD_EXPIRE, 0, 0, 0, 0, 0, 32'd200);
    send_item(it, 1'b1, ST_OK, 0);
    drain();

    // random phases with varied register settings, extremes included
    clock_s = 1000;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_EXPIRY, 16'd0); write_reg(REG_MIN_FRAG, 16'd1); end
        1: begin write_reg(REG_EXPIRY, 16'hFFFF); write_reg(REG_MIN_FRAG, 16'd0); end
        2: begin write_reg(REG_EXPIRY, 16'd30); write_reg(REG_MIN_FRAG, 16'd20); end
        3: begin write_reg(REG_EXPIRY, 16'd120); write_reg(REG_MIN_FRAG, 16'hFFFF); end
        4: begin
          write_reg(REG_EXPIRY, 16'($urandom)); write_reg(REG_MIN_FRAG, 16'($urandom_range(1, 80)));
        end
        default: begin
          write_reg(REG_EXPIRY, 16'd60); write_reg(REG_MIN_FRAG, 16'd40); no_idling = 1'b1;
        end
      endcase
      check_reg(REG_EXPIRY, 16'(expiry_s));
      for (int n = 0; n < 40; n += 1) begin
        clock_s += $urandom_range(0, 5);
        if ($urandom_range(0, 9) < 3) send_message(clock_s);
        else send_noise(clock_s);
        if ($urandom_range(0, 15) == 0) begin
          it = make_item(CMD_EXPIRE, 0, 0, 0, 0, 0, clock_s);
          send_item(it, 1'b0, ST_OK, -1);
        end
      end
      drain();
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
